>>> hdl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Beat structs for the box and result channels, the slot held in each cell
// of the ranking chain and the control group broadcast along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

  localparam int unsigned MaxBoxesDef = 64;
  localparam logic [15:0] IouThrReset = 16'd29491;

  // one input beat
  typedef struct packed {
    logic [15:0] box_cx;
    logic [15:0] box_cy;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] box_score;
    logic [7:0]  box_class;
    logic        final_box;
  } box_in_t;

  // one result beat
  typedef struct packed {
    logic [15:0] kept_cx;
    logic [15:0] kept_cy;
    logic [15:0] kept_w;
    logic [15:0] kept_h;
    logic [15:0] kept_score;
    logic [7:0]  kept_class;
    logic        end_of_list;
    logic        overflowed;
  } box_out_t;

  // stored box
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [7:0]  cls;
  } box_t;

  // contents of one cell
  typedef struct packed {
    logic valid;
    logic supp;
    box_t box;
  } slot_t;

  // chain operations
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } cell_op_e;

  // control broadcast to every cell
  typedef struct packed {
    cell_op_e op;
    box_t     new_box;
    box_t     head_box;
    logic     head_supp;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/greedy_box_suppression_top.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_top: class-agnostic greedy box suppression
// Boxes are ranked by descending score in a chain of cells as they arrive.
// The box marked final starts the suppression walk; kept boxes leave in rank
// order with the last one marked.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              beat
//  -------  ---  ---------------------  ---------------------------
//  in       in   in_valid_i/in_ready_o  box_in_t, one box
//  out      out  out_valid_o/out_ready_i box_out_t, one kept box
//  cfg      in   cfg_valid_i/cfg_ready_o iou threshold, Q0.16
//
//  A non-final box is taken while loading; the chain inserts it in order.
//  After the final box the walk pops each kept box from the head and tests
//  it in the four-stage overlap unit against each remaining box that is not
//  yet suppressed, marking those whose overlap with it exceeds the threshold.
//  Boxes are not taken during the walk; a stalled result beat holds the walk.
//  Reset empties the chain and restores the threshold to 29491.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression_top #(
  parameter int unsigned MAX_BOXES = gbs_pkg::MaxBoxesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gbs_pkg::box_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbs_pkg::box_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import gbs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            ovf_q, ovf_d;
  logic            busy_q, busy_d;
  logic            hold_v_q, hold_v_d;
  box_t            hold_q, hold_d;
  logic            out_v_q, out_v_d;
  box_out_t        out_q, out_d;
  logic [15:0]     thr_q;

  cell_ctl_t       ctl;
  slot_t           slots [MAX_BOXES];
  logic            ge [MAX_BOXES];
  slot_t           head;
  logic            in_acc;
  logic            iou_start, iou_done, iou_hit;
  box_t            new_box;

  assign head = slots[0];

  // threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= IouThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;

  assign new_box.cx    = in_data_i.box_cx;
  assign new_box.cy    = in_data_i.box_cy;
  assign new_box.w     = in_data_i.box_w;
  assign new_box.h     = in_data_i.box_h;
  assign new_box.score = in_data_i.box_score;
  assign new_box.cls   = in_data_i.box_class;

  // ranking chain
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    slot_t prev_s, next_s;
    logic  prev_ge;
    if (i == 0) begin : g_first
      assign prev_s  = '0;
      assign prev_ge = 1'b1;
    end else begin : g_mid
      assign prev_s  = slots[i-1];
      assign prev_ge = ge[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = slots[i+1];
    end
    gbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .prev_i    (prev_s),
      .prev_ge_i (prev_ge),
      .next_i    (next_s),
      .slot_o    (slots[i]),
      .ge_o      (ge[i])
    );
  end

  // overlap unit
  gbs_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .a_i     (hold_q),
    .b_i     (head.box),
    .thr_i   (thr_q),
    .done_o  (iou_done),
    .hit_o   (iou_hit)
  );

  // walk control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    ovf_d     = ovf_q;
    busy_d    = busy_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    out_v_d   = out_v_q && !out_ready_i;
    out_d     = out_q;
    iou_start = 1'b0;
    ctl.op        = OP_HOLD;
    ctl.new_box   = new_box;
    ctl.head_box  = head.box;
    ctl.head_supp = head.supp;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CntW'(MAX_BOXES)) begin
            ctl.op = OP_INSERT;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.final_box) begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        if (cnt_q == '0) begin
          state_d = ST_FLUSH;
        end else if (head.supp) begin
          ctl.op = OP_POP;
          cnt_d  = cnt_q - 1'b1;
        end else if (!(hold_v_q && out_v_q)) begin
          // emit the previous kept box, now known not to be the last
          if (hold_v_q) begin
            out_v_d = 1'b1;
            out_d   = '{hold_q.cx, hold_q.cy, hold_q.w, hold_q.h, hold_q.score,
                        hold_q.cls, 1'b0, ovf_q};
          end
          hold_v_d = 1'b1;
          hold_d   = head.box;
          ctl.op   = OP_POP;
          cnt_d    = cnt_q - 1'b1;
          rem_d    = cnt_q - 1'b1;
          if (cnt_q != CntW'(1)) begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (head.supp || iou_done) begin
          ctl.op        = OP_ROTATE;
          ctl.head_supp = head.supp || iou_hit;
          busy_d        = 1'b0;
          rem_d         = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = ST_HEAD;
          end
        end else if (!busy_q) begin
          iou_start = 1'b1;
          busy_d    = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!out_v_q) begin
          out_v_d  = 1'b1;
          out_d    = '{hold_q.cx, hold_q.cy, hold_q.w, hold_q.h, hold_q.score,
                       hold_q.cls, 1'b1, ovf_q};
          hold_v_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      rem_q    <= '0;
      ovf_q    <= 1'b0;
      busy_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      ovf_q    <= ovf_d;
      busy_q   <= busy_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.final_box) |=> !in_ready_o)
    else $error("box taken during suppression walk");

  a_iou_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iou_done |-> (state_q == ST_CMP && busy_q))
    else $error("overlap result outside compare");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (!hold_v_q && !busy_q))
    else $error("walk state left over while loading");

endmodule

`default_nettype wire

>>> hdl/gbs_cell.sv
// ----------------------------------------------------------------------------
// gbs_cell: one cell of the ranking chain
// Holds one box with its valid and suppressed bits. Takes part in sorted
// insertion, popping from the head and rotation of the head to the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbs_pkg::cell_ctl_t ctl_i,
  input  gbs_pkg::slot_t    prev_i,
  input  logic              prev_ge_i,
  input  gbs_pkg::slot_t    next_i,
  output gbs_pkg::slot_t    slot_o,
  output logic              ge_o
);
  import gbs_pkg::*;

  logic valid_q, valid_d;
  logic supp_q, supp_d;
  box_t box_q, box_d;

  // held box ranks at or above the incoming one (equal keeps arrival order)
  assign ge_o = valid_q && (box_q.score >= ctl_i.new_box.score);

  assign slot_o.valid = valid_q;
  assign slot_o.supp  = supp_q;
  assign slot_o.box   = box_q;

  // next contents
  always_comb begin
    valid_d = valid_q;
    supp_d  = supp_q;
    box_d   = box_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!ge_o) begin
          if (prev_ge_i) begin
            valid_d = 1'b1;
            supp_d  = 1'b0;
            box_d   = ctl_i.new_box;
          end else begin
            valid_d = prev_i.valid;
            supp_d  = prev_i.supp;
            box_d   = prev_i.box;
          end
        end
      end
      OP_POP: begin
        valid_d = next_i.valid;
        supp_d  = next_i.supp;
        box_d   = next_i.box;
      end
      OP_ROTATE: begin
        if (next_i.valid) begin
          valid_d = 1'b1;
          supp_d  = next_i.supp;
          box_d   = next_i.box;
        end else if (valid_q) begin
          supp_d = ctl_i.head_supp;
          box_d  = ctl_i.head_box;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      supp_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      supp_q  <= supp_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

endmodule

`default_nettype wire

>>> hdl/gbs_iou.sv
// ----------------------------------------------------------------------------
// gbs_iou: pipelined overlap test for one pair of boxes
// Four stages: edges and overlap, products, union, threshold product.
// Answers inter*65536 > thr*union, never true when the union is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_iou (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gbs_pkg::box_t a_i,
  input  gbs_pkg::box_t b_i,
  input  logic [15:0]   thr_i,
  output logic          done_o,
  output logic          hit_o
);
  import gbs_pkg::*;

  logic [3:0]  vld_q;
  logic [17:0] ix_q, iy_q;
  logic [15:0] aw_q, ah_q, bw_q, bh_q;
  logic [35:0] inter_q, inter3_q;
  logic [31:0] aa_q, bb_q;
  logic [35:0] uni_q;
  logic [51:0] prod_q, lhs_q;
  logic        nz_q;
  logic [17:0] ix_d, iy_d;

  // overlap along one axis in half-pixel units, clamped at zero
  function automatic logic [17:0] overlap(input logic [15:0] ca, input logic [15:0] sa,
                                          input logic [15:0] cb, input logic [15:0] sb);
    logic signed [19:0] alo, ahi, blo, bhi, lo, hi, diff;
    alo = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
    ahi = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
    blo = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
    bhi = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
    lo  = (alo > blo) ? alo : blo;
    hi  = (ahi < bhi) ? ahi : bhi;
    diff = hi - lo;
    overlap = diff[19] ? 18'd0 : diff[17:0];
  endfunction

  assign ix_d = overlap(a_i.cx, a_i.w, b_i.cx, b_i.w);
  assign iy_d = overlap(a_i.cy, a_i.h, b_i.cy, b_i.h);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    ix_q     <= ix_d;
    iy_q     <= iy_d;
    aw_q     <= a_i.w;
    ah_q     <= a_i.h;
    bw_q     <= b_i.w;
    bh_q     <= b_i.h;
    inter_q  <= ix_q * iy_q;
    aa_q     <= aw_q * ah_q;
    bb_q     <= bw_q * bh_q;
    uni_q    <= {2'b00, aa_q, 2'b00} + {2'b00, bb_q, 2'b00} - inter_q;
    inter3_q <= inter_q;
    prod_q   <= thr_i * uni_q;
    lhs_q    <= {inter3_q, 16'd0};
    nz_q     <= (uni_q != 36'd0);
  end

  assign done_o = vld_q[3];
  assign hit_o  = nz_q && (lhs_q > prod_q);

endmodule

`default_nettype wire
